// ===== src/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, phase codes and constants of the startup fade sequencer.
// ----------------------------------------------------------------------------
package lfs_pkg;

   // Sequence constants
   localparam logic [7:0] SAT_FIXED  = 8'd200;
   localparam logic [7:0] VAL_FULL   = 8'd255;
   localparam logic [7:0] FADE_STEP  = 8'd5;
   localparam logic [7:0] CYCLE_STEP = 8'd2;
   localparam logic [7:0] RAMP_STEPS = 8'd70;
   localparam logic [3:0] STEP_MS    = 4'd10;

   // Ramp arithmetic: base*70 offsets and divide-by-70 reciprocal
   localparam logic signed [16:0] RAMP_SAT_BASE = 17'sd14000;
   localparam logic signed [16:0] RAMP_VAL_BASE = 17'sd17850;
   localparam logic        [15:0] RAMP_RECIP    = 16'd59919;  // ceil(2^22 / 70)

   // Phase codes
   localparam logic [2:0] PH_START     = 3'd0;
   localparam logic [2:0] PH_FADE_OLD  = 3'd1;
   localparam logic [2:0] PH_FADE_IN   = 3'd2;
   localparam logic [2:0] PH_CYCLE     = 3'd3;
   localparam logic [2:0] PH_RAMP_DOWN = 3'd4;
   localparam logic [2:0] PH_RAMP_TO   = 3'd5;
   localparam logic [2:0] PH_CLEAN_UP  = 3'd6;
   localparam logic [2:0] PH_DONE      = 3'd7;

   // Mode classes
   localparam logic [1:0] MODE_RAMP_DOWN = 2'd0;
   localparam logic [1:0] MODE_RAMP_TO   = 2'd1;

   // Configuration register indexes
   localparam logic [2:0] CSR_SAVED_HUE = 3'd0;
   localparam logic [2:0] CSR_SAVED_SAT = 3'd1;
   localparam logic [2:0] CSR_SAVED_VAL = 3'd2;
   localparam logic [2:0] CSR_SAVED_EN  = 3'd3;
   localparam logic [2:0] CSR_MODE      = 3'd4;

   // Decoded step: result fields plus the ramp operands
   typedef struct packed {
      logic              set_color;
      logic [7:0]        hue;
      logic [7:0]        sat;
      logic [7:0]        val;
      logic              set_static_mode;
      logic              reload_settings;
      logic              finished;
      logic [3:0]        next_delay;
      logic              ramp;
      logic [6:0]        cnt;
      logic signed [8:0] sat_diff;
      logic signed [8:0] val_diff;
   } lfs_dec_type;

endpackage

// ===== src/lfs_req_if.sv =====
// ----------------------------------------------------------------------------
// lfs_req_if
// Step request channel: one item per tick while ready is high, advance or hold.
// ----------------------------------------------------------------------------
interface lfs_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

// ===== src/lfs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfs_rsp_if
// Result channel: LED commands for one step.
// ----------------------------------------------------------------------------
interface lfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       set_color;
   logic [7:0] hue_out;
   logic [7:0] sat_out;
   logic [7:0] val_out;
   logic       set_static_mode;
   logic       reload_settings;
   logic       finished;
   logic [3:0] next_delay;

   modport source (output valid, output set_color, output hue_out, output sat_out,
                   output val_out, output set_static_mode, output reload_settings,
                   output finished, output next_delay, input ready);
   modport sink   (input valid, input set_color, input hue_out, input sat_out,
                   input val_out, input set_static_mode, input reload_settings,
                   input finished, input next_delay, output ready);
endinterface

// ===== src/led_startup_fade_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// led_startup_fade_sequencer_unit
// Startup fade animation sequencer for an HSV LED strip, one step per item.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    advance
//   rsp_ch   out  valid/ready    set_color, hue/sat/val_out, set_static_mode,
//                                reload_settings, finished, next_delay
//   csr_*    in   csr_we         csr_index, csr_wdata (no read-back)
//
// One item per cycle sustained while rsp_ch takes results; an accepted item is
// registered in the decode register, then in the numerator register, then in
// the divide-by-70 register, from which its result is offered.
// State advances at acceptance, so items are taken while results wait.
// A stalled result holds the pipeline; a full pipeline drops req_ch.ready.
// Synchronous active-high reset clears state and settings to their defaults.
// ----------------------------------------------------------------------------
module led_startup_fade_sequencer_unit import lfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lfs_req_if.sink     req_ch,
   lfs_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   lfs_dec_type dec, out_dec;
   logic        req_ready;
   logic        step_en;
   logic [2:0]  phase;

   assign step_en = req_ch.valid && req_ready;

   // Sequencer state and step decode
   lfs_step u_step (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_en   (step_en),
      .advance   (req_ch.advance),
      .dec       (dec),
      .phase     (phase)
   );

   // Result pipeline
   lfs_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ready),
      .in_dec    (dec),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_dec   (out_dec)
   );

   assign req_ch.ready           = req_ready;
   assign rsp_ch.set_color       = out_dec.set_color;
   assign rsp_ch.hue_out         = out_dec.hue;
   assign rsp_ch.sat_out         = out_dec.sat;
   assign rsp_ch.val_out         = out_dec.val;
   assign rsp_ch.set_static_mode = out_dec.set_static_mode;
   assign rsp_ch.reload_settings = out_dec.reload_settings;
   assign rsp_ch.finished        = out_dec.finished;
   assign rsp_ch.next_delay      = out_dec.next_delay;

   // Done is terminal until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase == PH_DONE |=> phase == PH_DONE)
      else $error("sequencer left done phase");

   // Clean-up result carries finish and stop-repeat, no color
   a_cleanup_item: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.reload_settings |->
         rsp_ch.finished && rsp_ch.next_delay == 4'd0 && !rsp_ch.set_color)
      else $error("malformed clean-up item");

   // Color fields are zero when no color is applied
   a_no_color_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.set_color |->
         rsp_ch.hue_out == 8'd0 && rsp_ch.sat_out == 8'd0 && rsp_ch.val_out == 8'd0)
      else $error("color fields set without set_color");

endmodule

// ===== src/lfs_step.sv =====
// ----------------------------------------------------------------------------
// lfs_step
// Settings registers, phase/counter state and the per-step decode.
// ----------------------------------------------------------------------------
module lfs_step import lfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        step_en,
   input  logic        advance,
   output lfs_dec_type dec,
   output logic [2:0]  phase
);

   logic [7:0] hue_ff, sat_ff, val_ff;
   logic       en_ff;
   logic [1:0] mode_ff;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [2:0] ph_e;
   logic [7:0] cnt_e;
   logic [8:0] hue_sum;
   logic [7:0] hue_mod;

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff  <= 8'd0;
         sat_ff  <= 8'd255;
         val_ff  <= 8'd255;
         en_ff   <= 1'b1;
         mode_ff <= MODE_RAMP_TO;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAVED_HUE: hue_ff  <= csr_wdata;
            CSR_SAVED_SAT: sat_ff  <= csr_wdata;
            CSR_SAVED_VAL: val_ff  <= csr_wdata;
            CSR_SAVED_EN:  en_ff   <= csr_wdata[0];
            CSR_MODE:      mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Start phase folds into the first fade step
   assign ph_e  = (phase_ff == PH_START) ? PH_FADE_OLD : phase_ff;
   assign cnt_e = (phase_ff == PH_START) ? val_ff : cnt_ff;

   // (cnt + hue) mod 255
   assign hue_sum = {1'b0, cnt_e} + {1'b0, hue_ff};
   always_comb begin
      if (hue_sum >= 9'd510) begin
         hue_mod = 8'd0;
      end else if (hue_sum >= 9'd255) begin
         hue_mod = 8'(hue_sum - 9'd255);
      end else begin
         hue_mod = hue_sum[7:0];
      end
   end

   // Step decode and next state
   always_comb begin
      dec      = '0;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (!advance) begin
         dec.finished = (phase_ff == PH_DONE);
      end else begin
         dec.next_delay = STEP_MS;
         phase_in       = ph_e;
         cnt_in         = cnt_e;
         case (ph_e)
            PH_FADE_OLD: begin
               if (cnt_e >= FADE_STEP) begin
                  dec.set_color = 1'b1;
                  dec.hue       = hue_ff;
                  dec.sat       = sat_ff;
                  dec.val       = cnt_e;
                  cnt_in        = cnt_e - FADE_STEP;
               end else begin
                  cnt_in              = 8'd0;
                  phase_in            = PH_FADE_IN;
                  dec.set_static_mode = 1'b1;
               end
            end
            PH_FADE_IN: begin
               if (cnt_e < VAL_FULL) begin
                  dec.set_color = 1'b1;
                  dec.hue       = hue_ff;
                  dec.sat       = SAT_FIXED;
                  dec.val       = cnt_e;
                  cnt_in        = cnt_e + FADE_STEP;
               end else begin
                  cnt_in   = VAL_FULL;
                  phase_in = PH_CYCLE;
               end
            end
            PH_CYCLE: begin
               if (cnt_e >= CYCLE_STEP) begin
                  dec.set_color = 1'b1;
                  dec.hue       = hue_mod;
                  dec.sat       = SAT_FIXED;
                  dec.val       = VAL_FULL;
                  cnt_in        = cnt_e - CYCLE_STEP;
               end else if (mode_ff == MODE_RAMP_DOWN || !en_ff) begin
                  cnt_in   = VAL_FULL;
                  phase_in = PH_RAMP_DOWN;
               end else if (mode_ff == MODE_RAMP_TO) begin
                  cnt_in   = 8'd0;
                  phase_in = PH_RAMP_TO;
               end else begin
                  phase_in = PH_CLEAN_UP;
               end
            end
            PH_RAMP_DOWN: begin
               dec.set_color = 1'b1;
               dec.hue       = hue_ff;
               dec.sat       = SAT_FIXED;
               dec.val       = cnt_e;
               if (cnt_e >= FADE_STEP) begin
                  cnt_in = cnt_e - FADE_STEP;
               end else begin
                  phase_in = PH_CLEAN_UP;
               end
            end
            PH_RAMP_TO: begin
               if (cnt_e < RAMP_STEPS) begin
                  // sat/val are filled in by the ramp stages
                  dec.set_color = 1'b1;
                  dec.hue       = hue_ff;
                  dec.ramp      = 1'b1;
                  dec.cnt       = cnt_e[6:0];
                  dec.sat_diff  = $signed({1'b0, sat_ff}) - $signed({1'b0, SAT_FIXED});
                  dec.val_diff  = $signed({1'b0, val_ff}) - $signed({1'b0, VAL_FULL});
                  cnt_in        = cnt_e + 8'd1;
               end else begin
                  phase_in = PH_CLEAN_UP;
               end
            end
            PH_CLEAN_UP: begin
               dec.reload_settings = 1'b1;
               dec.finished        = 1'b1;
               dec.next_delay      = 4'd0;
               phase_in            = PH_DONE;
            end
            default: begin
               dec.finished = 1'b1;
            end
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         cnt_ff   <= 8'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign phase = phase_ff;

endmodule

// ===== src/lfs_pipe.sv =====
// ----------------------------------------------------------------------------
// lfs_pipe
// Three-stage result pipeline: decode register, ramp numerators,
// divide by 70 through a reciprocal multiply. Each stage moves when the
// next one is free or moving.
// ----------------------------------------------------------------------------
module lfs_pipe import lfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  lfs_dec_type in_dec,
   output logic        out_valid,
   input  logic        out_ready,
   output lfs_dec_type out_dec
);

   logic        v1_ff, v2_ff, v3_ff;
   logic        r1, r2, r3;
   lfs_dec_type d1_ff, d2_ff, d3_ff, d3_in;
   logic signed [16:0] prod_s, prod_v, sum_s, sum_v;
   logic [14:0] num_s_ff, num_v_ff;
   logic [30:0] quo_s, quo_v;

   // Ready chain
   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: decoded step
   always_ff @(posedge clock) begin
      if (r1) d1_ff <= in_dec;
   end

   // Stage 2: base*70 + c*(target-base)
   assign prod_s = 17'($signed({1'b0, d1_ff.cnt})) * 17'(d1_ff.sat_diff);
   assign prod_v = 17'($signed({1'b0, d1_ff.cnt})) * 17'(d1_ff.val_diff);
   assign sum_s  = RAMP_SAT_BASE + prod_s;
   assign sum_v  = RAMP_VAL_BASE + prod_v;

   always_ff @(posedge clock) begin
      if (r2) begin
         d2_ff    <= d1_ff;
         num_s_ff <= sum_s[14:0];
         num_v_ff <= sum_v[14:0];
      end
   end

   // Stage 3: exact floor(num / 70) for num below 2^17
   assign quo_s = {16'd0, num_s_ff} * {15'd0, RAMP_RECIP};
   assign quo_v = {16'd0, num_v_ff} * {15'd0, RAMP_RECIP};

   always_comb begin
      d3_in = d2_ff;
      if (d2_ff.ramp) begin
         d3_in.sat = quo_s[29:22];
         d3_in.val = quo_v[29:22];
      end
   end

   always_ff @(posedge clock) begin
      if (r3) d3_ff <= d3_in;
   end

   assign out_valid = v3_ff;
   assign out_dec   = d3_ff;

endmodule
